@@ sv/kmp_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types for the KMP matcher.
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int PATTERN_MAX = 128;
  localparam int POS_W       = 24;
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int TDATA_W     = ((POS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PAT_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TEXT_LONG = 2'd3;

  typedef struct packed {
    logic clear;
    logic pat_wr;
    logic first_link;
    logic seek_app;
    logic seek_txt;
    logic step;
    logic link_hit;
    logic link_miss;
    logic txt_hit;
    logic txt_miss;
    logic set_ovf_pat;
    logic set_ovf_txt;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic found;
    logic tc_max;
    logic eq;
    logic k_zero;
    logic out_valid;
  } dp_stat_t;

endpackage

@@ sv/kmp_datapath.sv @@
// Datapath: pattern and link memories, match state, text counter and result register.
`timescale 1ns / 1ps

module kmp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kmp_pkg::BYTE_W-1:0]    byte_in,
  input  kmp_pkg::dp_cmd_t              cmd,
  output kmp_pkg::dp_stat_t             stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [kmp_pkg::STATUS_W-1:0]  out_status,
  output logic [kmp_pkg::POS_W-1:0]     out_pos
);

  // Links are stored one above the textbook value, so zero stands for -1.
  logic [kmp_pkg::BYTE_W-1:0] pat_mem [kmp_pkg::PATTERN_MAX];
  logic [kmp_pkg::IDX_W-1:0]  fl_mem  [kmp_pkg::PATTERN_MAX];

  logic [kmp_pkg::BYTE_W-1:0] rd_pat;
  logic [kmp_pkg::IDX_W-1:0]  rd_fl;
  logic [kmp_pkg::IDX_W-1:0]  rd_addr;
  logic [kmp_pkg::IDX_W-1:0]  kidx;
  logic [kmp_pkg::BYTE_W-1:0] byte_reg;

  logic [kmp_pkg::LEN_W-1:0]  len;
  logic [kmp_pkg::LEN_W-1:0]  midx;
  logic [kmp_pkg::IDX_W-1:0]  last_fl;
  logic [kmp_pkg::POS_W-1:0]  tc;
  logic                       found;
  logic [kmp_pkg::POS_W-1:0]  found_pos;
  logic                       ovf_pat;
  logic                       ovf_txt;

  logic [kmp_pkg::IDX_W-1:0]  wr_idx;
  logic [kmp_pkg::IDX_W-1:0]  link_val;
  logic                       link_wr;
  logic [kmp_pkg::LEN_W-1:0]  k_plus;
  logic [kmp_pkg::POS_W-1:0]  tc_plus;
  logic [kmp_pkg::STATUS_W-1:0] res_status;
  logic [kmp_pkg::POS_W-1:0]  res_pos;

  assign wr_idx   = len[kmp_pkg::IDX_W-1:0];
  assign link_wr  = cmd.first_link | cmd.link_hit | cmd.link_miss;
  assign link_val = cmd.link_hit ? (kidx + kmp_pkg::IDX_W'(1)) : '0;
  assign k_plus   = kmp_pkg::LEN_W'(kidx) + kmp_pkg::LEN_W'(1);
  assign tc_plus  = tc + kmp_pkg::POS_W'(1);

  always_comb begin
    if (cmd.seek_app) begin
      rd_addr = last_fl;
    end else if (cmd.seek_txt) begin
      rd_addr = midx[kmp_pkg::IDX_W-1:0];
    end else begin
      rd_addr = rd_fl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pat_wr) begin
      pat_mem[wr_idx] <= byte_in;
    end
    if (link_wr) begin
      fl_mem[wr_idx] <= link_val;
    end
    rd_pat <= pat_mem[rd_addr];
    rd_fl  <= fl_mem[rd_addr - kmp_pkg::IDX_W'(1)];
  end

  always_ff @(posedge clk) begin
    if (cmd.seek_app || cmd.seek_txt || cmd.step) begin
      kidx <= rd_addr;
    end
    if (cmd.pat_wr || cmd.seek_txt) begin
      byte_reg <= byte_in;
    end
  end

  always_comb begin
    if (ovf_pat) begin
      res_status = kmp_pkg::ST_PAT_LONG;
      res_pos    = '0;
    end else if (len == '0) begin
      res_status = kmp_pkg::ST_FOUND;
      res_pos    = '0;
    end else if (found) begin
      res_status = kmp_pkg::ST_FOUND;
      res_pos    = found_pos;
    end else if (ovf_txt) begin
      res_status = kmp_pkg::ST_TEXT_LONG;
      res_pos    = '0;
    end else begin
      res_status = kmp_pkg::ST_NOT_FOUND;
      res_pos    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      len     <= '0;
      midx    <= '0;
      last_fl <= '0;
      tc      <= '0;
      found   <= 1'b0;
      ovf_pat <= 1'b0;
      ovf_txt <= 1'b0;
    end else begin
      if (cmd.set_ovf_pat) begin
        ovf_pat <= 1'b1;
      end
      if (cmd.set_ovf_txt) begin
        ovf_txt <= 1'b1;
      end
      if (link_wr) begin
        last_fl <= link_val;
        len     <= len + kmp_pkg::LEN_W'(1);
      end
      if (cmd.txt_hit) begin
        tc <= tc_plus;
        if (k_plus == len) begin
          found <= 1'b1;
          midx  <= len;
        end else begin
          midx <= k_plus;
        end
      end
      if (cmd.txt_miss) begin
        tc   <= tc_plus;
        midx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      found_pos <= '0;
    end else if (cmd.txt_hit && k_plus == len) begin
      found_pos <= tc_plus - kmp_pkg::POS_W'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_pos    <= res_pos;
    end
  end

  assign stat.len_zero  = (len == '0);
  assign stat.len_full  = (len == kmp_pkg::LEN_W'(kmp_pkg::PATTERN_MAX));
  assign stat.found     = found;
  assign stat.tc_max    = (tc == '1);
  assign stat.eq        = (byte_reg == rd_pat);
  assign stat.k_zero    = (kidx == '0);
  assign stat.out_valid = out_valid;

  a_midx_bound: assert property (@(posedge clk) disable iff (rst)
    !found |-> (midx < len) || (len == '0))
    else $error("match index reached pattern length without a match");

  a_link_bound: assert property (@(posedge clk) disable iff (rst)
    (len != '0) |-> (kmp_pkg::LEN_W'(last_fl) < len))
    else $error("last failure link points past the pattern");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while still held");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    (cmd.txt_hit && k_plus == len) |=> found)
    else $error("full match did not set the found flag");

endmodule

@@ sv/kmp_ctrl.sv @@
// Controller: request decode and the state machine that sequences link lookups.
`timescale 1ns / 1ps

module kmp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [kmp_pkg::CMD_W-1:0]  in_cmd,
  output logic                       in_ready,
  input  logic                       out_ready,
  input  kmp_pkg::dp_stat_t          stat,
  output kmp_pkg::dp_cmd_t           cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACMP = 2'd1;
  localparam logic [1:0] S_TCMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // Lookups stall requests; end-of-text also waits while a result is held.
  assign in_ready = (state == S_IDLE) &&
                    ((in_cmd != kmp_pkg::CMD_END) || !stat.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            kmp_pkg::CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            kmp_pkg::CMD_APPEND: begin
              if (stat.len_full) begin
                cmd.set_ovf_pat = 1'b1;
              end else if (stat.len_zero) begin
                cmd.pat_wr     = 1'b1;
                cmd.first_link = 1'b1;
              end else begin
                cmd.pat_wr   = 1'b1;
                cmd.seek_app = 1'b1;
                state_next   = S_ACMP;
              end
            end
            kmp_pkg::CMD_TEXT: begin
              if (stat.found || stat.len_zero) begin
                cmd = '0;
              end else if (stat.tc_max) begin
                cmd.set_ovf_txt = 1'b1;
              end else begin
                cmd.seek_txt = 1'b1;
                state_next   = S_TCMP;
              end
            end
            kmp_pkg::CMD_END: begin
              cmd.load_out = 1'b1;
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      S_ACMP: begin
        if (stat.eq) begin
          cmd.link_hit = 1'b1;
          state_next   = S_IDLE;
        end else if (stat.k_zero) begin
          cmd.link_miss = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_TCMP: begin
        if (stat.eq) begin
          cmd.txt_hit = 1'b1;
          state_next  = S_IDLE;
        end else if (stat.k_zero) begin
          cmd.txt_miss = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("request taken while a lookup is in progress");

  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.link_hit, cmd.link_miss, cmd.txt_hit, cmd.txt_miss, cmd.step}) <= 1)
    else $error("conflicting compare outcomes issued together");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (state == S_ACMP || state == S_TCMP))
    else $error("link step left the compare state");

endmodule

@@ sv/kmp_substring_matcher_unit.sv @@
// Top level of the KMP substring matcher: controller plus datapath behind stream ports.
//
//   port group  dir  tdata            tuser
//   s_*         in   data_byte[7:0]   cmd[1:0]
//   m_*         out  match_position   status[1:0]
//
// Clear, end-of-text, dropped bytes and the first pattern byte finish in the idle state.
// Other pattern and text bytes go on to a compare state that steps the failure links,
// using the registered read of the pattern and link memories. Reset is synchronous and
// needs no clearing pass: unwritten memory entries are never read. A lookup stalls all
// requests; end-of-text also stalls while the previous result is held with m_tready low.
`timescale 1ns / 1ps

module kmp_substring_matcher_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kmp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic [kmp_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kmp_pkg::TDATA_W-1:0]   m_tdata,   // [23:0] match_position
  output logic [kmp_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

  kmp_pkg::dp_cmd_t             dp_cmd;
  kmp_pkg::dp_stat_t            dp_stat;
  logic [kmp_pkg::POS_W-1:0]    out_pos;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  kmp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (s_tdata),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_pos    (out_pos)
  );

  assign m_tdata = kmp_pkg::TDATA_W'(out_pos);

endmodule

@@ bench/kmp_substring_matcher_unit_tb.sv @@
// Self-checking testbench for the KMP substring matcher: a directed table, then random jobs.
`timescale 1ns / 1ps

module kmp_substring_matcher_unit_tb;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    logic [kmp_pkg::STATUS_W-1:0] status;
    logic [kmp_pkg::TDATA_W-1:0]  position;
  } match_result_t;

  typedef struct {
    logic [kmp_pkg::CMD_W-1:0]    cmd;
    logic [kmp_pkg::BYTE_W-1:0]   data;
    int                           reps;
    bit                           typed;
    logic [kmp_pkg::STATUS_W-1:0] status;
    logic [kmp_pkg::TDATA_W-1:0]  position;
  } stim_row_t;

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [kmp_pkg::BYTE_W-1:0]   s_tdata  = '0;
  logic [kmp_pkg::CMD_W-1:0]    s_tuser  = kmp_pkg::CMD_CLEAR;
  logic                         m_tvalid;
  logic                         m_tready = 1'b1;
  logic [kmp_pkg::TDATA_W-1:0]  m_tdata;
  logic [kmp_pkg::STATUS_W-1:0] m_tuser;

  kmp_substring_matcher_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted search state.
  logic [kmp_pkg::BYTE_W-1:0] pat_mem  [kmp_pkg::PATTERN_MAX];
  int                         link_mem [kmp_pkg::PATTERN_MAX];
  int unsigned                pat_len;
  int unsigned                match_idx;
  logic [kmp_pkg::POS_W-1:0]  text_cnt;
  logic [kmp_pkg::POS_W-1:0]  found_pos;
  bit                         found;
  bit                         ovf_pat;
  bit                         ovf_txt;

  match_result_t pending_outcomes [$];
  stim_row_t     directed_rows [DIRECTED_ROWS];

  int  errors          = 0;
  int  results_checked = 0;
  int  items_counted   = 0;
  int  jobs_run        = 0;
  int  cycle_count     = 0;
  int  src_idle_pct    = 25;
  bit  idle_on         = 1'b1;

  task automatic clear_search_state();
    pat_len   = 0;
    match_idx = 0;
    text_cnt  = '0;
    found_pos = '0;
    found     = 1'b0;
    ovf_pat   = 1'b0;
    ovf_txt   = 1'b0;
  endtask

  task automatic search_step(input logic [kmp_pkg::CMD_W-1:0] cmd,
                             input logic [kmp_pkg::BYTE_W-1:0] b);
    int          i;
    int unsigned j;
    case (cmd)
      kmp_pkg::CMD_CLEAR: clear_search_state();
      kmp_pkg::CMD_APPEND: begin
        if (pat_len >= kmp_pkg::PATTERN_MAX) begin
          ovf_pat = 1'b1;
        end else begin
          pat_mem[pat_len] = b;
          if (pat_len == 0) begin
            link_mem[0] = -1;
          end else begin
            // Walk the link chain of the stored prefix until the next byte extends it.
            i = link_mem[pat_len-1];
            while (i >= 0 && b != pat_mem[i+1]) i = link_mem[i];
            link_mem[pat_len] = (b == pat_mem[i+1]) ? i + 1 : -1;
          end
          pat_len++;
        end
      end
      kmp_pkg::CMD_TEXT: begin
        // Text is ignored after a match and while the pattern is empty.
        if (!found && pat_len != 0) begin
          if (text_cnt == '1) begin
            ovf_txt = 1'b1;
          end else begin
            j = match_idx;
            forever begin
              if (j < pat_len && b == pat_mem[j]) begin
                j++;
                break;
              end
              if (j == 0 || j > pat_len) break;
              j = link_mem[j-1] + 1;
            end
            text_cnt++;
            if (j >= pat_len) begin
              found     = 1'b1;
              found_pos = text_cnt - kmp_pkg::POS_W'(pat_len);
              j         = pat_len;
            end
            match_idx = j;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic match_result_t search_outcome();
    match_result_t r;
    r.position = '0;
    if (ovf_pat)           r.status = kmp_pkg::ST_PAT_LONG;
    else if (pat_len == 0) r.status = kmp_pkg::ST_FOUND;
    else if (found) begin
      r.status   = kmp_pkg::ST_FOUND;
      r.position = kmp_pkg::TDATA_W'(found_pos);
    end
    else if (ovf_txt)      r.status = kmp_pkg::ST_TEXT_LONG;
    else                   r.status = kmp_pkg::ST_NOT_FOUND;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Drives one request and waits for its handshake, then updates the prediction.
  task automatic send_request(input logic [kmp_pkg::CMD_W-1:0] cmd,
                              input logic [kmp_pkg::BYTE_W-1:0] data,
                              input bit use_typed = 1'b0, input match_result_t typed = '0);
    int gap;
    if (idle_on && $urandom_range(1, 100) <= src_idle_pct) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    search_step(cmd, data);
    if (cmd == kmp_pkg::CMD_END)
      pending_outcomes.push_back(use_typed ? typed : search_outcome());
    items_counted++;
  endtask

  task automatic run_random_job();
    logic [kmp_pkg::BYTE_W-1:0] pat_q [$];
    logic [kmp_pkg::BYTE_W-1:0] txt_q [$];
    logic [kmp_pkg::BYTE_W-1:0] base;
    int kind;
    int plen;
    int span;
    int at;
    int extra_at;
    int n;
    kind = $urandom_range(0, 99);
    base = 8'($urandom);
    span = $urandom_range(2, 3);
    src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
    if (kind < 76) begin
      if (kind >= 72) begin
        // Long two-symbol patterns around the capacity, some of them overflowing.
        plen = $urandom_range(kmp_pkg::PATTERN_MAX - 2, kmp_pkg::PATTERN_MAX + 3);
        span = 2;
      end else if ($urandom_range(0, 7) == 0) begin
        plen = $urandom_range(7, 24);
      end else begin
        plen = $urandom_range(1, 6);
      end
      send_request(kmp_pkg::CMD_CLEAR, 8'($urandom));
      for (int k = 0; k < plen; k++) begin
        pat_q.push_back(base + 8'($urandom_range(0, span - 1)));
        send_request(kmp_pkg::CMD_APPEND, pat_q[k]);
      end
      n = $urandom_range(0, 30);
      for (int k = 0; k < n; k++) txt_q.push_back(base + 8'($urandom_range(0, span - 1)));
      if ($urandom_range(0, 1) == 0) begin
        at = $urandom_range(0, txt_q.size());
        for (int k = 0; k < plen; k++) txt_q.insert(at + k, pat_q[k]);
      end
      extra_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, txt_q.size()) : -1;
      for (int k = 0; k < txt_q.size(); k++) begin
        if (k == extra_at)
          send_request(kmp_pkg::CMD_APPEND, base + 8'($urandom_range(0, span - 1)));
        send_request(kmp_pkg::CMD_TEXT, txt_q[k]);
      end
      send_request(kmp_pkg::CMD_END, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_request(kmp_pkg::CMD_END, 8'($urandom));
    end else if (kind < 90) begin
      // Carry on with the current job: more pattern and text bytes mixed.
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++)
        send_request(($urandom_range(0, 2) == 0) ? kmp_pkg::CMD_APPEND : kmp_pkg::CMD_TEXT,
                     base + 8'($urandom_range(0, span - 1)));
      send_request(kmp_pkg::CMD_END, 8'($urandom));
    end else begin
      n = $urandom_range(3, 12);
      for (int k = 0; k < n; k++) send_request(2'($urandom), 8'($urandom));
      send_request(kmp_pkg::CMD_END, 8'($urandom));
    end
  endtask

  // Sink side: random bursts of back-pressure.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 10);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    match_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result status %0d position %0d", m_tuser, m_tdata));
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (m_tuser !== want.status || m_tdata !== want.position)
          note_failure($sformatf("status exp %0d got %0d, position exp %0d got %0d",
                                 want.status, m_tuser, want.position, m_tdata));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{kmp_pkg::CMD_END,    8'hA5, 1, 1'b1, kmp_pkg::ST_FOUND,     '0},  // empty after reset
      '{kmp_pkg::CMD_TEXT,   8'hFF, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},  // ignored, no pattern
      '{kmp_pkg::CMD_END,    8'h5A, 1, 1'b1, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_APPEND, 8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_APPEND, 8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_APPEND, 8'hFF, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},  // falls back one link
      '{kmp_pkg::CMD_TEXT,   8'hFF, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_END,    8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},  // after the match
      '{kmp_pkg::CMD_END,    8'hFF, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},  // repeated end
      '{kmp_pkg::CMD_CLEAR,  8'hFF, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_APPEND, 8'h55, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'hAA, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_END,    8'h00, 1, 1'b1, kmp_pkg::ST_NOT_FOUND, '0},
      '{kmp_pkg::CMD_APPEND, 8'hAA, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},  // grows after text
      '{kmp_pkg::CMD_TEXT,   8'h55, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_TEXT,   8'hAA, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_END,    8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_CLEAR,  8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      // One byte past capacity.
      '{kmp_pkg::CMD_APPEND, 8'h7E, kmp_pkg::PATTERN_MAX + 1, 1'b0, kmp_pkg::ST_FOUND, '0},
      '{kmp_pkg::CMD_TEXT,   8'h7E, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_END,    8'h00, 1, 1'b1, kmp_pkg::ST_PAT_LONG,  '0},
      '{kmp_pkg::CMD_CLEAR,  8'h00, 1, 1'b0, kmp_pkg::ST_FOUND,     '0},
      '{kmp_pkg::CMD_END,    8'h00, 1, 1'b1, kmp_pkg::ST_FOUND,     '0}
    };
    clear_search_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_request(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].typed,
                     '{status: directed_rows[r].status, position: directed_rows[r].position});

    while (items_counted < ITEM_TARGET) begin
      idle_on = (items_counted < ITEM_TARGET * 9 / 10);
      run_random_job();
      jobs_run++;
    end
    idle_on  = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_outcomes.size()));

    $display("Ran %0d directed rows and %0d random jobs (%0d requests in all).",
             DIRECTED_ROWS, jobs_run, items_counted);
    $display("Checked %0d end-of-text results, %0d failures in %0d cycles.",
             results_checked, errors, cycle_count);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/kmp_pkg.sv
sv/kmp_datapath.sv
sv/kmp_ctrl.sv
sv/kmp_substring_matcher_unit.sv
bench/kmp_substring_matcher_unit_tb.sv
